>>> rtl/rle_pkg.sv
// Shared types, constants and header encoding for the RGBA run-length encoder.
package rle_pkg;

  localparam logic [6:0] RUN_MAX   = 7'h7f;
  localparam logic [7:0] PACK_FLAG = 8'h80;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  typedef struct packed {
    logic [6:0] len;
    pixel_t     pix;
  } run_t;

  typedef struct packed {
    logic has_prev;
    run_t prev;
    logic has_final;
    run_t fin;
  } cmd_t;

  function automatic logic [7:0] header_of(input logic [6:0] len);
    logic [7:0] hdr;
    if (len <= 7'd1) begin
      hdr = 8'h00;
    end else begin
      hdr = PACK_FLAG | {1'b0, len};
    end
    return hdr;
  endfunction

endpackage

>>> rtl/rle_front.sv
// Front end: accepts pixels, tracks the open run and issues record commands.
module rle_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  rle_pkg::pixel_t pix,
  input  logic          last,
  input  logic          q_full,
  output logic          push,
  output rle_pkg::cmd_t cmd
);
  import rle_pkg::*;

  pixel_t     run_pix_r, run_pix_nxt;
  logic [6:0] run_len_r, run_len_nxt;
  logic       accept;
  logic       extend;
  pixel_t     new_pix;
  logic [6:0] new_len;

  always_comb begin
    accept = in_valid && !q_full;
    extend = (run_len_r != 7'd0) && (pix == run_pix_r) && (run_len_r < RUN_MAX);
    new_len = extend ? run_len_r + 7'd1 : 7'd1;
    new_pix = extend ? run_pix_r : pix;

    cmd.has_prev  = !extend && (run_len_r != 7'd0);
    cmd.prev.len  = run_len_r;
    cmd.prev.pix  = run_pix_r;
    cmd.has_final = last;
    cmd.fin.len   = new_len;
    cmd.fin.pix   = new_pix;

    push = accept && (cmd.has_prev || last);

    run_pix_nxt = run_pix_r;
    run_len_nxt = run_len_r;
    if (accept) begin
      if (last) begin
        run_pix_nxt = '0;
        run_len_nxt = 7'd0;
      end else begin
        run_pix_nxt = new_pix;
        run_len_nxt = new_len;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_pix_r <= '0;
      run_len_r <= 7'd0;
    end else begin
      run_pix_r <= run_pix_nxt;
      run_len_r <= run_len_nxt;
    end
  end

endmodule

>>> rtl/rle_queue.sv
// Command queue between the front end and the record emitter.
module rle_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rle_pkg::cmd_t wr_data,
  input  logic          pop,
  output rle_pkg::cmd_t rd_data,
  output logic          empty,
  output logic          full
);
  import rle_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  cmd_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  always_comb begin
    empty   = (count_r == '0);
    full    = (count_r == CNT_FULL);
    rd_data = mem_r[rd_ptr_r];

    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

>>> rtl/rle_back.sv
// Back end: expands queued commands into records and holds the output register.
module rle_back (
  input  logic          clk,
  input  logic          rst_n,
  input  rle_pkg::cmd_t head,
  input  logic          q_empty,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_header,
  output rle_pkg::pixel_t out_pix,
  output logic          out_final
);
  import rle_pkg::*;

  logic       out_valid_r, out_valid_nxt;
  logic       pend_r, pend_nxt;
  logic [7:0] hdr_r;
  pixel_t     pix_r;
  logic       final_r;
  logic       load;
  logic       load_rec;
  run_t       rec;
  logic       rec_final;

  always_comb begin
    load          = !out_valid_r || !out_stall;
    out_valid_nxt = out_valid_r && out_stall;
    pend_nxt      = pend_r;
    pop           = 1'b0;
    load_rec      = 1'b0;
    rec           = head.fin;
    rec_final     = 1'b1;
    if (load && !q_empty) begin
      out_valid_nxt = 1'b1;
      load_rec      = 1'b1;
      if (pend_r) begin
        pop      = 1'b1;
        pend_nxt = 1'b0;
      end else if (head.has_prev) begin
        rec       = head.prev;
        rec_final = 1'b0;
        if (head.has_final) begin
          pend_nxt = 1'b1;
        end else begin
          pop = 1'b1;
        end
      end else begin
        pop = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_rec) begin
      hdr_r   <= header_of(rec.len);
      pix_r   <= rec.pix;
      final_r <= rec_final;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_header = hdr_r;
  assign out_pix    = pix_r;
  assign out_final  = final_r;

endmodule

>>> rtl/rgba_run_length_encoder_top.sv
// Top level of the RGBA run-length encoder.
// A record closed by a pixel request goes through the command queue into the output register.
// Throughput: one pixel per cycle unless in_stall; one record out per cycle unless out_stall.
// A last pixel that also closes an earlier run yields two records, the earlier run first.
// in_stall rises only when the QUEUE_DEPTH-entry command queue is full.
// Reset (rst_n low, synchronous) closes no run: it drops the open run, the queue and the output.
module rgba_run_length_encoder_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_red,
  input  logic [7:0] in_green,
  input  logic [7:0] in_blue,
  input  logic [7:0] in_alpha,
  input  logic       in_last_pixel,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_header,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic [7:0] out_alpha,
  output logic       out_final_record
);
  import rle_pkg::*;

  pixel_t in_pix;
  pixel_t res_pix;
  cmd_t   push_cmd;
  cmd_t   head_cmd;
  logic   push;
  logic   pop;
  logic   q_empty;
  logic   q_full;

  assign in_pix.red   = in_red;
  assign in_pix.green = in_green;
  assign in_pix.blue  = in_blue;
  assign in_pix.alpha = in_alpha;
  assign in_stall     = q_full;

  rle_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .pix     (in_pix),
    .last    (in_last_pixel),
    .q_full  (q_full),
    .push    (push),
    .cmd     (push_cmd)
  );

  rle_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_data(push_cmd),
    .pop    (pop),
    .rd_data(head_cmd),
    .empty  (q_empty),
    .full   (q_full)
  );

  rle_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head_cmd),
    .q_empty   (q_empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_header(out_header),
    .out_pix   (res_pix),
    .out_final (out_final_record)
  );

  assign out_red   = res_pix.red;
  assign out_green = res_pix.green;
  assign out_blue  = res_pix.blue;
  assign out_alpha = res_pix.alpha;

endmodule

>>> rtl/rle_checker.sv
// Port-level checks for the RGBA run-length encoder, bound to the top level.
module rle_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] in_red,
  input logic [7:0] in_green,
  input logic [7:0] in_blue,
  input logic [7:0] in_alpha,
  input logic       in_last_pixel,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_header,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue,
  input logic [7:0] out_alpha,
  input logic       out_final_record
);

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_header) && $stable(out_red)
      && $stable(out_green) && $stable(out_blue) && $stable(out_alpha)
      && $stable(out_final_record))
    else $error("stalled record changed");

  a_header_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_header == 8'h00) || (out_header[7] && (out_header[6:1] != 6'd0)))
    else $error("malformed header");

  a_stall_needs_request: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(in_valid && !in_stall))
    else $error("in_stall rose without a pixel request");

endmodule

bind rgba_run_length_encoder_top rle_checker u_rle_checker (.*);

>>> tb/rgba_run_length_encoder_top_test.sv
// Self-checking testbench for the RGBA run-length encoder top level.
module rgba_run_length_encoder_top_test;
  import rle_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    logic [7:0] header;
    pixel_t     pix;
    logic       final_rec;
  } record_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;
  logic [7:0] in_alpha;
  logic       in_last_pixel;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_header;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] out_alpha;
  logic       out_final_record;

  record_t    pending_records[$];
  pixel_t     open_pix;
  logic [6:0] open_len;
  int         mismatch_count;
  int         cycle_count;
  bit         no_idle;

  rgba_run_length_encoder_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_red           (in_red),
    .in_green         (in_green),
    .in_blue          (in_blue),
    .in_alpha         (in_alpha),
    .in_last_pixel    (in_last_pixel),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_header       (out_header),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_alpha        (out_alpha),
    .out_final_record (out_final_record)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic [7:0] run_header(input logic [6:0] len);
    logic [7:0] hdr;
    hdr = (len <= 7'd1) ? 8'h00 : (PACK_FLAG | {1'b0, len});
    return hdr;
  endfunction

  function automatic record_t close_run(input bit is_final);
    record_t rec;
    rec.header    = run_header(open_len);
    rec.pix       = open_pix;
    rec.final_rec = is_final;
    return rec;
  endfunction

  task automatic encode_pixel(input pixel_t pix, input bit last);
    if (open_len != 7'd0 && pix == open_pix && open_len < RUN_MAX) begin
      open_len = open_len + 7'd1;
    end else begin
      if (open_len != 7'd0) begin
        pending_records.push_back(close_run(1'b0));
      end
      open_pix = pix;
      open_len = 7'd1;
    end
    if (last) begin
      pending_records.push_back(close_run(1'b1));
      open_pix = '0;
      open_len = 7'd0;
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    mismatch_count++;
  endtask

  task automatic send_pixel(input pixel_t pix, input bit last);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_red        <= pix.red;
    in_green      <= pix.green;
    in_blue       <= pix.blue;
    in_alpha      <= pix.alpha;
    in_last_pixel <= last;
    in_valid      <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    encode_pixel(pix, last);
  endtask

  task automatic wait_for_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_records.size() != 0) @(posedge clk);
  endtask

  function automatic pixel_t random_pixel();
    return pixel_t'($urandom);
  endfunction

  function automatic pixel_t make_pixel(input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b, input logic [7:0] a);
    pixel_t pix;
    pix.red   = r;
    pix.green = g;
    pix.blue  = b;
    pix.alpha = a;
    return pix;
  endfunction

  task automatic test_extremes();
    send_pixel(make_pixel(8'h00, 8'h00, 8'h00, 8'h00), 1'b1);
    send_pixel(make_pixel(8'hff, 8'hff, 8'hff, 8'hff), 1'b0);
    send_pixel(make_pixel(8'hff, 8'hff, 8'hff, 8'hff), 1'b0);
    send_pixel(make_pixel(8'hff, 8'hff, 8'hff, 8'hff), 1'b1);
    send_pixel(make_pixel(8'h55, 8'haa, 8'h55, 8'haa), 1'b0);
    send_pixel(make_pixel(8'haa, 8'h55, 8'haa, 8'h55), 1'b0);
    send_pixel(make_pixel(8'h00, 8'h00, 8'h00, 8'h00), 1'b0);
    send_pixel(make_pixel(8'h00, 8'h00, 8'h00, 8'h01), 1'b1);
  endtask

  // Two records on one last pixel: the earlier run goes out first.
  task automatic test_record_order();
    pixel_t pa;
    pixel_t pb;
    pa = random_pixel();
    pb = pa ^ 32'h8000_0000;
    send_pixel(pa, 1'b0);
    send_pixel(pa, 1'b0);
    send_pixel(pb, 1'b1);
    send_pixel(pb, 1'b0);
    send_pixel(pb, 1'b0);
    send_pixel(pa, 1'b1);
  endtask

  task automatic test_single_pixel_images();
    pixel_t pix;
    pix = random_pixel();
    repeat (3) send_pixel(pix, 1'b1);
    send_pixel(random_pixel(), 1'b1);
    send_pixel(random_pixel(), 1'b1);
  endtask

  // Fill a run to the cap exactly, then overflow it by three pixels and by one.
  task automatic test_full_run();
    pixel_t pix;
    pix = random_pixel();
    for (int i = 0; i < 127; i++) send_pixel(pix, i == 126);
    for (int i = 0; i < 130; i++) send_pixel(pix, i == 129);
    for (int i = 0; i < 128; i++) send_pixel(pix, i == 127);
  endtask

  // Hold the input with a run still open until every record has drained.
  task automatic test_drain_pause();
    pixel_t pix;
    pix = random_pixel();
    send_pixel(pix, 1'b0);
    send_pixel(pix ^ 32'h0000_0001, 1'b0);
    send_pixel(pix ^ 32'h0000_0001, 1'b0);
    wait_for_drain();
    send_pixel(pix ^ 32'h0000_0001, 1'b0);
    send_pixel(pix, 1'b1);
    wait_for_drain();
  endtask

  task automatic test_random_images(input int pixel_budget);
    pixel_t palette[4];
    pixel_t pix;
    int     sent;
    int     image_len;
    int     run_len;
    int     done;
    int     image_count;
    sent = 0;
    image_count = 0;
    while (sent < pixel_budget) begin
      image_len = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 260)
                                               : $urandom_range(1, 24);
      palette[0] = random_pixel();
      palette[1] = palette[0] ^ (32'h1 << $urandom_range(0, 31));
      palette[2] = random_pixel();
      palette[3] = pixel_t'(32'h0);
      no_idle = ($urandom_range(0, 4) == 0);
      done = 0;
      while (done < image_len) begin
        run_len = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 140)
                                               : $urandom_range(1, 5);
        pix = ($urandom_range(0, 7) == 0) ? random_pixel() : palette[$urandom_range(0, 3)];
        for (int k = 0; k < run_len && done < image_len; k++) begin
          send_pixel(pix, done == image_len - 1);
          done++;
        end
      end
      sent += image_len;
      image_count++;
      if (image_count % 15 == 14) begin
        wait_for_drain();
      end
    end
    no_idle = 1'b0;
  endtask

  // Raise out_stall for a random number of cycles before each record, and never while no_idle is set.
  initial begin
    int hold;
    out_stall = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, 9);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    record_t rec;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_records.size() == 0) begin
        report_mismatch($sformatf("unexpected record header %02h", out_header));
      end else begin
        rec = pending_records.pop_front();
        if (out_header !== rec.header)
          report_mismatch($sformatf("header %02h, want %02h", out_header, rec.header));
        if (out_red !== rec.pix.red)
          report_mismatch($sformatf("red %02h, want %02h", out_red, rec.pix.red));
        if (out_green !== rec.pix.green)
          report_mismatch($sformatf("green %02h, want %02h", out_green, rec.pix.green));
        if (out_blue !== rec.pix.blue)
          report_mismatch($sformatf("blue %02h, want %02h", out_blue, rec.pix.blue));
        if (out_alpha !== rec.pix.alpha)
          report_mismatch($sformatf("alpha %02h, want %02h", out_alpha, rec.pix.alpha));
        if (out_final_record !== rec.final_rec)
          report_mismatch($sformatf("final_record %0b, want %0b",
                                    out_final_record, rec.final_rec));
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("rgba_run_length_encoder_top_test: FAIL");
    $finish;
  end

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_red        = 8'h00;
    in_green      = 8'h00;
    in_blue       = 8'h00;
    in_alpha      = 8'h00;
    in_last_pixel = 1'b0;
    no_idle       = 1'b0;
    mismatch_count = 0;
    open_pix      = '0;
    open_len      = 7'd0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_extremes();
    test_record_order();
    test_single_pixel_images();
    test_full_run();
    test_drain_pause();
    test_random_images(1200);

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("rgba_run_length_encoder_top_test: PASS");
    end else begin
      $display("rgba_run_length_encoder_top_test: FAIL");
    end
    $finish;
  end

endmodule
